// ===== hdl/dhpu_pkg.sv =====
// Shared item types and record codes for the detector hit packet unpacker.
package dhpu_pkg;

    localparam logic [2:0] KIND_HIT        = 3'd0;
    localparam logic [2:0] KIND_CCNT_ERROR = 3'd1;
    localparam logic [2:0] KIND_CCNT_BAD   = 3'd2;
    localparam logic [2:0] KIND_FAULTY     = 3'd3;
    localparam logic [2:0] KIND_DONE       = 3'd4;

    localparam logic [7:0] CFG_NUM_CHIPS = 8'd0;
    localparam logic [7:0] CFG_NUM_BANKS = 8'd1;

    typedef struct packed {
        logic [15:0] data_word;
        logic        packet_start;
    } word_item_t;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [3:0]  bank_index;
        logic [13:0] bank_marker;
        logic [7:0]  chip_number;
        logic [3:0]  channel_number;
        logic [13:0] high_gain_value;
        logic [13:0] low_gain_value;
        logic [13:0] hit_time;
        logic [19:0] packet_length;
        logic [31:0] faulty_hit_count;
    } record_item_t;

    typedef struct packed {
        logic [7:0] num_chips;
        logic [3:0] num_banks;
    } cfg_t;

endpackage

// ===== hdl/detector_hit_packet_unpacker.sv =====
// Top level of the detector hit packet unpacker: input register, parser, result register.
// A record passes through the input register and then the result register before it shows on record_valid.
// One word per cycle while record_stall does not hold back the record register, set by the single decode
// path from the word register through the phase decoder into the record register.
// Reset (rst_n low, asynchronous): parser idle, all counters and sums zero,
// num_chips and num_banks back to 1, no item held in either register.
module detector_hit_packet_unpacker #(
    parameter int MAX_BANKS = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   word_valid,
    output logic                   word_stall,
    input  dhpu_pkg::word_item_t   word,
    output logic                   record_valid,
    input  logic                   record_stall,
    output dhpu_pkg::record_item_t record,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [7:0]             cfg_index,
    input  logic [7:0]             cfg_data
);

    logic                   in_valid_reg, in_valid_next;
    dhpu_pkg::word_item_t   in_data_reg;
    logic                   out_valid_reg, out_valid_next;
    dhpu_pkg::record_item_t out_data_reg;
    dhpu_pkg::cfg_t         cfg_reg, cfg_next;

    logic                   consume;
    logic                   accept;
    logic                   res_valid;
    dhpu_pkg::record_item_t res;

    // advance the held word whenever the record register can take a result
    assign consume    = in_valid_reg && !(out_valid_reg && record_stall);
    assign word_stall = in_valid_reg && !consume;
    assign accept     = word_valid && !word_stall;
    assign cfg_ready  = 1'b1;

    assign record_valid = out_valid_reg;
    assign record       = out_data_reg;

    dhpu_parser #(
        .MAX_BANKS (MAX_BANKS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (consume),
        .item      (in_data_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (consume)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (consume)
        begin
            out_valid_next = res_valid;
        end
        else if (!record_stall)
        begin
            out_valid_next = 1'b0;
        end

        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == dhpu_pkg::CFG_NUM_CHIPS)
            begin
                cfg_next.num_chips = cfg_data;
            end
            else if (cfg_index == dhpu_pkg::CFG_NUM_BANKS)
            begin
                cfg_next.num_banks = cfg_data[3:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg       <= '{num_chips: 8'd1, num_banks: 4'd1};
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_data_reg <= word;
        end
        if (consume && res_valid)
        begin
            out_data_reg <= res;
        end
    end

endmodule

// ===== hdl/dhpu_parser.sv =====
// Packet parse state and per-word decode for the hit packet unpacker.
module dhpu_parser #(
    parameter int MAX_BANKS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  dhpu_pkg::word_item_t  item,
    input  dhpu_pkg::cfg_t        cfg,
    output logic                  res_valid,
    output dhpu_pkg::record_item_t res
);

    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_WCLO  = 4'd1;
    localparam logic [3:0] PH_WCHI  = 4'd2;
    localparam logic [3:0] PH_CCNT  = 4'd3;
    localparam logic [3:0] PH_STAMP = 4'd4;
    localparam logic [3:0] PH_TAG   = 4'd5;
    localparam logic [3:0] PH_HIGH  = 4'd6;
    localparam logic [3:0] PH_LOW   = 4'd7;
    localparam logic [3:0] PH_TIME  = 4'd8;
    localparam logic [3:0] PH_PAD   = 4'd9;
    localparam logic [3:0] PH_MARK  = 4'd10;

    localparam logic [4:0] MaxBanks = 5'(MAX_BANKS);

    logic [3:0]  phase_reg, phase_next;
    logic [3:0]  bank_reg, bank_next;
    logic [12:0] pos_reg, pos_next;
    logic [11:0] ccnt_reg, ccnt_next;
    logic [15:0] wcnt_reg, wcnt_next;
    logic [13:0] marker_reg, marker_next;
    logic [12:0] tag_reg, tag_next;
    logic [13:0] high_reg, high_next;
    logic [13:0] low_reg, low_next;
    logic [19:0] lsum_reg, lsum_next;
    logic [31:0] faulty_reg, faulty_next;

    logic [3:0]  phase_v;
    logic [3:0]  bank_v;
    logic [19:0] lsum_v;
    logic [12:0] pos_v;
    logic [13:0] pos_inc;
    logic [13:0] hits_end;
    logic [13:0] bank_len;
    logic [22:0] ccnt_limit;
    logic [4:0]  banks_used;
    logic [7:0]  chip;
    logic        emit;
    logic [15:0] w;

    always_comb
    begin
        w = item.data_word;
        // a start flag restarts the packet whatever is in progress
        phase_v = item.packet_start ? PH_MARK : phase_reg;
        bank_v  = item.packet_start ? 4'd0 : bank_reg;
        lsum_v  = item.packet_start ? 20'd0 : lsum_reg;
        pos_v   = item.packet_start ? 13'd0 : pos_reg;

        pos_inc    = {1'b0, pos_v} + 14'd1;
        hits_end   = 14'd8 + {ccnt_reg[11:2], 2'b00};
        bank_len   = {2'b00, ccnt_reg} + 14'd10 + {13'd0, ~ccnt_reg[0]};
        ccnt_limit = {1'b0, wcnt_reg, 6'd0} + {3'd0, wcnt_reg, 4'd0};
        chip       = tag_reg[12:5];

        banks_used = {1'b0, cfg.num_banks};
        if (banks_used == 5'd0)
        begin
            banks_used = 5'd1;
        end
        if (banks_used > MaxBanks)
        begin
            banks_used = MaxBanks;
        end

        phase_next  = phase_v;
        bank_next   = bank_v;
        pos_next    = pos_inc[12:0];
        ccnt_next   = ccnt_reg;
        wcnt_next   = wcnt_reg;
        marker_next = marker_reg;
        tag_next    = tag_reg;
        high_next   = high_reg;
        low_next    = low_reg;
        lsum_next   = lsum_v;
        faulty_next = faulty_reg;
        emit        = 1'b0;
        res         = '0;

        unique case (phase_v)
            PH_IDLE:
            begin
                pos_next = pos_reg;
            end
            PH_MARK:
            begin
                marker_next = w[13:0];
                pos_next    = 13'd1;
                phase_next  = PH_WCLO;
            end
            PH_WCLO:
            begin
                wcnt_next  = w;
                lsum_next  = lsum_v + {4'd0, w};
                phase_next = PH_WCHI;
            end
            PH_WCHI:
            begin
                phase_next = PH_CCNT;
            end
            PH_CCNT:
            begin
                if (w > 16'd4095)
                begin
                    emit            = 1'b1;
                    res.record_kind = dhpu_pkg::KIND_CCNT_ERROR;
                    phase_next      = PH_IDLE;
                end
                else if ({7'd0, w} > ccnt_limit)
                begin
                    emit            = 1'b1;
                    res.record_kind = dhpu_pkg::KIND_CCNT_BAD;
                    phase_next      = PH_IDLE;
                end
                else
                begin
                    ccnt_next  = w[11:0];
                    phase_next = PH_STAMP;
                end
            end
            PH_STAMP:
            begin
                if (pos_v >= 13'd7)
                begin
                    phase_next = (ccnt_reg[11:2] != 10'd0) ? PH_TAG : PH_PAD;
                end
            end
            PH_TAG:
            begin
                tag_next   = w[12:0];
                phase_next = PH_HIGH;
            end
            PH_HIGH:
            begin
                high_next  = w[13:0];
                phase_next = PH_LOW;
            end
            PH_LOW:
            begin
                low_next   = w[13:0];
                phase_next = PH_TIME;
            end
            PH_TIME:
            begin
                emit            = 1'b1;
                res.record_kind = dhpu_pkg::KIND_HIT;
                if (!(chip >= 8'd1 && chip <= cfg.num_chips))
                begin
                    faulty_next     = faulty_reg + 32'd1;
                    res.record_kind = dhpu_pkg::KIND_FAULTY;
                end
                res.chip_number     = chip;
                res.channel_number  = tag_reg[3:0];
                res.high_gain_value = high_reg;
                res.low_gain_value  = low_reg;
                res.hit_time        = w[13:0];
                phase_next = (pos_inc < hits_end) ? PH_TAG : PH_PAD;
            end
            PH_PAD:
            begin
                if (pos_inc >= bank_len)
                begin
                    if ({1'b0, bank_v} + 5'd1 >= banks_used)
                    begin
                        emit              = 1'b1;
                        res.record_kind   = dhpu_pkg::KIND_DONE;
                        res.packet_length = lsum_v + 20'd6;
                        phase_next        = PH_IDLE;
                    end
                    else
                    begin
                        bank_next  = bank_v + 4'd1;
                        pos_next   = 13'd0;
                        phase_next = PH_MARK;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        res.bank_index       = bank_v;
        res.bank_marker      = (phase_v == PH_MARK) ? marker_reg : marker_reg;
        res.faulty_hit_count = faulty_next;
        res_valid            = step && emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            bank_reg   <= 4'd0;
            pos_reg    <= 13'd0;
            ccnt_reg   <= 12'd0;
            wcnt_reg   <= 16'd0;
            marker_reg <= 14'd0;
            tag_reg    <= 13'd0;
            high_reg   <= 14'd0;
            low_reg    <= 14'd0;
            lsum_reg   <= 20'd0;
            faulty_reg <= 32'd0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            bank_reg   <= bank_next;
            pos_reg    <= pos_next;
            ccnt_reg   <= ccnt_next;
            wcnt_reg   <= wcnt_next;
            marker_reg <= marker_next;
            tag_reg    <= tag_next;
            high_reg   <= high_next;
            low_reg    <= low_next;
            lsum_reg   <= lsum_next;
            faulty_reg <= faulty_next;
        end
    end

endmodule

// ===== verif/tb_detector_hit_packet_unpacker.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the detector hit packet unpacker: directed table, then random packets.
module tb_detector_hit_packet_unpacker;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 6;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_BANKS      = 10;
    localparam int PHASE_WORDS    = 160;
    localparam int NUM_PHASES     = 8;
    localparam int MAX_REPORTS    = 10;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_WC_LO,
        PH_WC_HI,
        PH_CCNT,
        PH_STAMP,
        PH_TAG,
        PH_HIGH,
        PH_LOW,
        PH_TIME,
        PH_PAD,
        PH_MARK
    } parse_phase_e;

    typedef struct {
        dhpu_pkg::word_item_t   item;
        bit                     typed;
        dhpu_pkg::record_item_t rec;
    } directed_row_t;

    logic                   clk;
    logic                   rst_n        = 1'b0;
    logic                   word_valid   = 1'b0;
    logic                   word_stall;
    dhpu_pkg::word_item_t   word         = '0;
    logic                   record_valid;
    logic                   record_stall = 1'b0;
    dhpu_pkg::record_item_t record;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [7:0]             cfg_index    = '0;
    logic [7:0]             cfg_data     = '0;

    // Predictor copy of the registers and parser state
    logic [7:0]   chip_limit;
    logic [3:0]   bank_setting;
    parse_phase_e phase;
    logic [3:0]   bank_no;
    logic [12:0]  bank_pos;
    logic [11:0]  chan_count;
    logic [15:0]  word_count;
    logic [13:0]  marker_low;
    logic [15:0]  tag_word;
    logic [13:0]  high_gain;
    logic [13:0]  low_gain;
    logic [19:0]  length_acc;
    logic [31:0]  faulty_hits;

    dhpu_pkg::record_item_t expected_records [$];
    dhpu_pkg::word_item_t   word_plan [$];
    int                     mismatches  = 0;
    int                     idle_cycles = 0;
    bit                     calm        = 1'b0;

    detector_hit_packet_unpacker #(
        .MAX_BANKS(MAX_BANKS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .word_valid  (word_valid),
        .word_stall  (word_stall),
        .word        (word),
        .record_valid(record_valid),
        .record_stall(record_stall),
        .record      (record),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic void reset_predictor();
        chip_limit   = 8'd1;
        bank_setting = 4'd1;
        phase        = PH_IDLE;
        bank_no      = '0;
        bank_pos     = '0;
        chan_count   = '0;
        word_count   = '0;
        marker_low   = '0;
        tag_word     = '0;
        high_gain    = '0;
        low_gain     = '0;
        length_acc   = '0;
        faulty_hits  = '0;
    endfunction

    function automatic int unsigned banks_per_packet();
        if (bank_setting == 4'd0)
            return 1;
        if (int'(bank_setting) > MAX_BANKS)
            return MAX_BANKS;
        return int'(bank_setting);
    endfunction

    function automatic dhpu_pkg::record_item_t base_record(input logic [2:0] kind);
        dhpu_pkg::record_item_t r;
        r                  = '0;
        r.record_kind      = kind;
        r.bank_index       = bank_no;
        r.bank_marker      = marker_low;
        r.faulty_hit_count = faulty_hits;
        return r;
    endfunction

    // Record of bank 0 with no faulty hits seen yet
    function automatic dhpu_pkg::record_item_t typed_record(input logic [2:0] kind,
                                                            input logic [13:0] marker,
                                                            input logic [19:0] length);
        dhpu_pkg::record_item_t r;
        r               = '0;
        r.record_kind   = kind;
        r.bank_marker   = marker;
        r.packet_length = length;
        return r;
    endfunction

    task automatic parse_word(input dhpu_pkg::word_item_t wi, output bit made,
                              output dhpu_pkg::record_item_t rec);
        logic [12:0] pos;
        int unsigned hits_end;
        int unsigned bank_len;
        logic [7:0]  chip;
        made = 1'b0;
        rec  = '0;
        if (wi.packet_start)
        begin
            bank_no    = '0;
            length_acc = '0;
            phase      = PH_MARK;
            bank_pos   = '0;
        end
        if (phase == PH_IDLE)
            return;
        pos      = bank_pos;
        bank_pos = pos + 13'd1;
        hits_end = 8 + 4 * int'(chan_count >> 2);
        case (phase)
            PH_MARK:
            begin
                marker_low = wi.data_word[13:0];
                bank_pos   = 13'd1;
                phase      = PH_WC_LO;
            end
            PH_WC_LO:
            begin
                word_count = wi.data_word;
                length_acc = length_acc + 20'(wi.data_word);
                phase      = PH_WC_HI;
            end
            PH_WC_HI:
                phase = PH_CCNT;
            PH_CCNT:
            begin
                if (int'(wi.data_word) > 4095)
                begin
                    rec   = base_record(dhpu_pkg::KIND_CCNT_ERROR);
                    made  = 1'b1;
                    phase = PH_IDLE;
                end
                else if (int'(wi.data_word) > int'(word_count) * 80)
                begin
                    rec   = base_record(dhpu_pkg::KIND_CCNT_BAD);
                    made  = 1'b1;
                    phase = PH_IDLE;
                end
                else
                begin
                    chan_count = wi.data_word[11:0];
                    phase      = PH_STAMP;
                end
            end
            PH_STAMP:
                if (int'(pos) >= 7)
                    phase = (hits_end > 8) ? PH_TAG : PH_PAD;
            PH_TAG:
            begin
                tag_word = wi.data_word;
                phase    = PH_HIGH;
            end
            PH_HIGH:
            begin
                high_gain = wi.data_word[13:0];
                phase     = PH_LOW;
            end
            PH_LOW:
            begin
                low_gain = wi.data_word[13:0];
                phase    = PH_TIME;
            end
            PH_TIME:
            begin
                chip = tag_word[12:5];
                if (chip >= 8'd1 && chip <= chip_limit)
                    rec = base_record(dhpu_pkg::KIND_HIT);
                else
                begin
                    // count first: the record carries the updated total
                    faulty_hits = faulty_hits + 32'd1;
                    rec         = base_record(dhpu_pkg::KIND_FAULTY);
                end
                rec.chip_number     = chip;
                rec.channel_number  = tag_word[3:0];
                rec.high_gain_value = high_gain;
                rec.low_gain_value  = low_gain;
                rec.hit_time        = wi.data_word[13:0];
                made                = 1'b1;
                phase               = (int'(pos) + 1 < hits_end) ? PH_TAG : PH_PAD;
            end
            PH_PAD:
            begin
                bank_len = int'(chan_count) + 10 + (chan_count[0] ? 0 : 1);
                if (int'(pos) + 1 >= bank_len)
                begin
                    if (int'(bank_no) + 1 >= banks_per_packet())
                    begin
                        rec               = base_record(dhpu_pkg::KIND_DONE);
                        rec.packet_length = length_acc + 20'd6;
                        made              = 1'b1;
                        phase             = PH_IDLE;
                    end
                    else
                    begin
                        bank_no  = bank_no + 4'd1;
                        bank_pos = '0;
                        phase    = PH_MARK;
                    end
                end
            end
            default:
                phase = PH_IDLE;
        endcase
    endtask

    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_word(input dhpu_pkg::word_item_t wi, input bit typed,
                             input dhpu_pkg::record_item_t typed_rec);
        int                     gap;
        bit                     made;
        dhpu_pkg::record_item_t rec;
        gap = pick_gap();
        if (gap > 0)
        begin
            word_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        word_valid <= 1'b1;
        word       <= wi;
        do @(negedge clk); while (word_stall);
        @(posedge clk);
        parse_word(wi, made, rec);
        if (typed)
            expected_records.push_back(typed_rec);
        else if (made)
            expected_records.push_back(rec);
    endtask

    // Wait out every pending record, then the pipeline, so the block is idle
    task automatic drain();
        word_valid <= 1'b0;
        while (expected_records.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [7:0] chips, input logic [3:0] banks);
        cfg_valid <= 1'b1;
        cfg_index <= dhpu_pkg::CFG_NUM_CHIPS;
        cfg_data  <= chips;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        chip_limit = chips;
        cfg_index <= dhpu_pkg::CFG_NUM_BANKS;
        cfg_data  <= {4'($urandom), banks};
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        bank_setting = banks;
        cfg_valid <= 1'b0;
    endtask

    function automatic void plan_word(input logic [15:0] data, input bit start);
        dhpu_pkg::word_item_t wi;
        wi.data_word    = data;
        wi.packet_start = start;
        word_plan.push_back(wi);
    endfunction

    // err_kind: 0 well formed, 1 count above 4095, 2 count above 80 times the word count
    function automatic void plan_bank(input bit first, input int err_kind, input int forced_count);
        int          count;
        int          min_wc;
        int          wc;
        int          n_hits;
        int          pads;
        logic [15:0] tag;
        logic [7:0]  chip;
        plan_word(16'($urandom), first);
        if (err_kind == 2)
        begin
            wc    = $urandom_range(0, 51);
            count = 80 * wc + ($urandom_range(0, 1) ? 1 : $urandom_range(1, 4095 - 80 * wc));
        end
        else
        begin
            if (forced_count >= 0)
                count = forced_count;
            else if ($urandom_range(0, 9) == 0)
                count = $urandom_range(25, 200);
            else
                count = $urandom_range(0, 24);
            min_wc = (count + 79) / 80;
            case ($urandom_range(0, 3))
                0:       wc = min_wc;
                1:       wc = $urandom_range(min_wc, 65535);
                default: wc = $urandom_range(min_wc, min_wc + 40);
            endcase
        end
        plan_word(16'(wc), 1'b0);
        plan_word(16'($urandom), 1'b0);
        if (err_kind == 1)
        begin
            plan_word(($urandom_range(0, 3) == 0) ? 16'd4096 : 16'($urandom_range(4096, 65535)),
                      1'b0);
            return;
        end
        plan_word(16'(count), 1'b0);
        if (err_kind == 2)
            return;
        repeat (4) plan_word(16'($urandom), 1'b0);
        n_hits = count / 4;
        repeat (n_hits)
        begin
            tag = 16'($urandom);
            case ($urandom_range(0, 5))
                0:       chip = chip_limit;
                1:       chip = chip_limit + 8'd1;
                2:       chip = 8'($urandom);
                default: chip = (chip_limit == 8'd0) ? 8'd0 : 8'($urandom_range(1, chip_limit));
            endcase
            tag[12:5] = chip;
            plan_word(tag, 1'b0);
            repeat (3) plan_word(16'($urandom), 1'b0);
        end
        pads = count + 10 + ((count % 2 == 0) ? 1 : 0) - (8 + 4 * n_hits);
        repeat (pads) plan_word(16'($urandom), 1'b0);
    endfunction

    function automatic void plan_packet();
        int roll;
        int banks;
        int err_bank;
        int first_idx;
        int drop;
        roll  = $urandom_range(0, 99);
        banks = banks_per_packet();
        if (roll < 5)
        begin
            // stray words outside any packet
            repeat ($urandom_range(1, 3)) plan_word(16'($urandom), 1'b0);
            return;
        end
        err_bank  = (roll < 15) ? $urandom_range(0, banks - 1) : -1;
        first_idx = word_plan.size();
        for (int b = 0; b < banks; b++)
        begin
            if (b == err_bank)
            begin
                plan_bank(b == 0, $urandom_range(1, 2), -1);
                break;
            end
            plan_bank(b == 0, 0, -1);
        end
        // cut the packet short; the next start flag abandons it
        if (roll >= 15 && roll < 22)
        begin
            drop = $urandom_range(1, word_plan.size() - first_idx - 1);
            repeat (drop) void'(word_plan.pop_back());
        end
    endfunction

    function automatic void note_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] seen);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, seen);
    endfunction

    task automatic check_record(input dhpu_pkg::record_item_t got);
        dhpu_pkg::record_item_t want;
        if (expected_records.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: record of kind %0d with nothing expected", $time, got.record_kind);
            return;
        end
        want = expected_records.pop_front();
        if (got.record_kind !== want.record_kind)
            note_mismatch("record_kind", want.record_kind, got.record_kind);
        if (got.bank_index !== want.bank_index)
            note_mismatch("bank_index", want.bank_index, got.bank_index);
        if (got.bank_marker !== want.bank_marker)
            note_mismatch("bank_marker", want.bank_marker, got.bank_marker);
        if (got.chip_number !== want.chip_number)
            note_mismatch("chip_number", want.chip_number, got.chip_number);
        if (got.channel_number !== want.channel_number)
            note_mismatch("channel_number", want.channel_number, got.channel_number);
        if (got.high_gain_value !== want.high_gain_value)
            note_mismatch("high_gain_value", want.high_gain_value, got.high_gain_value);
        if (got.low_gain_value !== want.low_gain_value)
            note_mismatch("low_gain_value", want.low_gain_value, got.low_gain_value);
        if (got.hit_time !== want.hit_time)
            note_mismatch("hit_time", want.hit_time, got.hit_time);
        if (got.packet_length !== want.packet_length)
            note_mismatch("packet_length", want.packet_length, got.packet_length);
        if (got.faulty_hit_count !== want.faulty_hit_count)
            note_mismatch("faulty_hit_count", want.faulty_hit_count, got.faulty_hit_count);
    endtask

    // Inputs settle after the rising edge, so the negedge sees what the next edge accepts
    always @(negedge clk)
    begin
        if (rst_n && record_valid && !record_stall)
            check_record(record);
    end

    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                stall_left--;
                record_stall <= 1'b1;
            end
            else
                record_stall <= 1'b0;
        end
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(negedge clk);
            if ((word_valid && !word_stall) || (record_valid && !record_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb_detector_hit_packet_unpacker: done, errors");
        $finish;
    end

    initial
    begin
        directed_row_t rows [0:25];
        logic [7:0]    chip_plan [0:NUM_PHASES-1];
        logic [3:0]    bank_plan [0:NUM_PHASES-1];
        int            sent;
        reset_predictor();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows = '{
            '{'{16'hFFFF, 1'b0}, 1'b0, '0},     // idle word, ignored
            '{'{16'hFFFF, 1'b1}, 1'b0, '0},
            '{'{16'h0000, 1'b0}, 1'b0, '0},
            '{'{16'h0000, 1'b1}, 1'b0, '0},     // restart mid-packet
            '{'{16'h0000, 1'b0}, 1'b0, '0},
            '{'{16'hFFFF, 1'b0}, 1'b0, '0},
            '{'{16'h0001, 1'b0}, 1'b1,
              typed_record(dhpu_pkg::KIND_CCNT_BAD, 14'h0000, 20'd0)},
            '{'{16'hFFFF, 1'b1}, 1'b0, '0},
            '{'{16'hFFFF, 1'b0}, 1'b0, '0},
            '{'{16'h0000, 1'b0}, 1'b0, '0},
            '{'{16'hFFFF, 1'b0}, 1'b1,
              typed_record(dhpu_pkg::KIND_CCNT_ERROR, 14'h3FFF, 20'd0)},
            '{'{16'hC123, 1'b1}, 1'b0, '0},
            '{'{16'h0001, 1'b0}, 1'b0, '0},
            '{'{16'h1234, 1'b0}, 1'b0, '0},
            '{'{16'h0004, 1'b0}, 1'b0, '0},     // one hit
            '{'{16'hAAAA, 1'b0}, 1'b0, '0},
            '{'{16'h5555, 1'b0}, 1'b0, '0},
            '{'{16'hFFFF, 1'b0}, 1'b0, '0},
            '{'{16'h0000, 1'b0}, 1'b0, '0},
            '{'{16'hE03F, 1'b0}, 1'b0, '0},     // chip 1, channel 15
            '{'{16'hFFFF, 1'b0}, 1'b0, '0},
            '{'{16'hC000, 1'b0}, 1'b0, '0},
            '{'{16'h7FFF, 1'b0}, 1'b0, '0},
            '{'{16'h1357, 1'b0}, 1'b0, '0},
            '{'{16'hFFFF, 1'b0}, 1'b0, '0},
            '{'{16'h0000, 1'b0}, 1'b1,
              typed_record(dhpu_pkg::KIND_DONE, 14'h0123, 20'd7)}
        };
        foreach (rows[i])
            send_word(rows[i].item, rows[i].typed, rows[i].rec);
        drain();

        chip_plan = '{8'd255, 8'd0, 8'd7, 8'd200, 8'd3, 8'd1, 8'd255, 8'($urandom)};
        bank_plan = '{4'd10, 4'd2, 4'd0, 4'd15, 4'd3, 4'd1, 4'd1, 4'($urandom_range(1, 4))};
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_config(chip_plan[p], bank_plan[p]);
            calm = (p % 3 == 2);
            sent = 0;
            // one bank at a large odd channel count
            if (p == 6)
                plan_bank(1'b1, 0, 301);
            while (sent < PHASE_WORDS)
            begin
                if (word_plan.size() == 0)
                    plan_packet();
                sent += word_plan.size();
                while (word_plan.size() != 0)
                    send_word(word_plan.pop_front(), 1'b0, '0);
            end
            drain();
        end

        if (mismatches == 0 && expected_records.size() == 0)
            $display("tb_detector_hit_packet_unpacker: done, clean");
        else
            $display("tb_detector_hit_packet_unpacker: done, errors");
        $finish;
    end

endmodule
